/* design/cls_pkg.sv */
// ============================================================================
// cls_pkg: shared types and constants of the script tokenizer
// Lexer modes, token kinds, the result record and the byte classifier.
// ============================================================================
`default_nettype none

package cls_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WORD  = 3'd1,
        MODE_STR   = 3'd2,
        MODE_CHR   = 3'd3,
        MODE_LCOM  = 3'd4,
        MODE_BCOM  = 3'd5,
        MODE_BSTAR = 3'd6
    } lex_mode_t;

    typedef enum logic [1:0] {
        KIND_WORD = 2'd0,
        KIND_OP   = 2'd1,
        KIND_STR  = 2'd2,
        KIND_CHR  = 2'd3
    } tok_kind_t;

    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = 2;
    localparam int Q_CNT_BITS = 3;

    // One token byte without its line number.
    typedef struct packed {
        logic      has;
        logic [7:0] ch;
        logic      start;
        tok_kind_t kind;
    } tok_res_t;

    // Fixed part of one queue entry: one or two beats caused by one input byte.
    typedef struct packed {
        logic     fin;
        logic     two;
        tok_res_t r0;
        tok_res_t r1;
    } cls_entry_t;

    // Outcome of one content byte in the current mode.
    typedef struct packed {
        lex_mode_t mode;
        logic      slash;
        logic      take;
        logic      emit;
        tok_res_t  res;
    } cont_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_opbyte(input logic [7:0] c);
        logic r;
        unique case (c) inside
            8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h25, 8'h3d, 8'h21, 8'h26, 8'h7c,
            8'h3e, 8'h3c, 8'h5c, 8'h3a, 8'h3b, 8'h22, 8'h27, 8'h28, 8'h29,
            8'h5b, 8'h5d, 8'h7b, 8'h7d, 8'h2e, 8'h2c, 8'h3f, 8'h23: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Mode after a line break.
    function automatic lex_mode_t new_line_mode(input lex_mode_t m);
        lex_mode_t r;
        r = m;
        if (m == MODE_WORD || m == MODE_LCOM)
            r = MODE_IDLE;
        else if (m == MODE_BSTAR)
            r = MODE_BCOM;
        return r;
    endfunction

    // Handles one byte that is not a line feed, with no slash held.
    function automatic cont_t lex_content(input lex_mode_t m, input logic [7:0] c);
        cont_t r;
        r.mode      = m;
        r.slash     = 1'b0;
        r.take      = 1'b0;
        r.emit      = 1'b0;
        r.res.has   = 1'b1;
        r.res.ch    = c;
        r.res.start = 1'b0;
        r.res.kind  = KIND_WORD;
        case (m)
            MODE_STR:
            begin
                r.emit     = 1'b1;
                r.res.kind = KIND_STR;
                if (c == CH_DQUOTE)
                    r.mode = MODE_IDLE;
            end
            MODE_CHR:
            begin
                r.emit     = 1'b1;
                r.res.kind = KIND_CHR;
                if (c == CH_SQUOTE)
                    r.mode = MODE_IDLE;
            end
            MODE_LCOM:
            begin
            end
            MODE_BCOM:
            begin
                if (c == CH_STAR)
                    r.mode = MODE_BSTAR;
            end
            MODE_BSTAR:
            begin
                if (c == CH_SLASH)
                    r.mode = MODE_IDLE;
                else if (c != CH_STAR)
                    r.mode = MODE_BCOM;
            end
            default:
            begin
                if (is_space(c)) begin
                    r.mode = MODE_IDLE;
                end else if (is_opbyte(c)) begin
                    r.mode      = MODE_IDLE;
                    r.take      = 1'b1;
                    r.res.start = 1'b1;
                    if (c == CH_DQUOTE) begin
                        r.mode     = MODE_STR;
                        r.emit     = 1'b1;
                        r.res.kind = KIND_STR;
                    end else if (c == CH_SQUOTE) begin
                        r.mode     = MODE_CHR;
                        r.emit     = 1'b1;
                        r.res.kind = KIND_CHR;
                    end else if (c == CH_SLASH) begin
                        r.slash = 1'b1;
                    end else begin
                        r.emit     = 1'b1;
                        r.res.kind = KIND_OP;
                    end
                end else if (m == MODE_WORD) begin
                    r.emit = 1'b1;
                end else begin
                    r.mode      = MODE_WORD;
                    r.take      = 1'b1;
                    r.emit      = 1'b1;
                    r.res.start = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/cls_front.sv */
// ============================================================================
// cls_front: byte classifier and lexer mode machine
// Decides each accepted byte combinationally and pushes its beats to the queue.
// ============================================================================
`default_nettype none

module cls_front #(
    parameter int LINE_BITS = 20
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 final_byte,
    input  wire logic                 q_full,
    output logic                      push,
    output cls_pkg::cls_entry_t       push_info,
    output logic [LINE_BITS-1:0]      push_line0,
    output logic [LINE_BITS-1:0]      push_line1
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam int NCAND = 5;

    cls_pkg::lex_mode_t    mode_reg, mode_next;
    logic                  slash_reg, slash_next;
    logic                  cr_reg, cr_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    logic [LINE_BITS-1:0]  tok_line_reg, tok_line_next;

    cls_pkg::lex_mode_t    mode_w;
    logic                  slash_w, cr_w, done_w, found0, found1;
    logic [LINE_BITS-1:0]  lc_w, tl_w;
    cls_pkg::cont_t        cont_a, cont_b;
    logic [NCAND-1:0]      ev;
    cls_pkg::tok_res_t     er [NCAND];
    logic [LINE_BITS-1:0]  el [NCAND];
    logic                  accept;

    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
        return (v == LINE_MAX) ? v : v + {{(LINE_BITS-1){1'b0}}, 1'b1};
    endfunction

    assign accept = in_valid && !q_full;

    // The step is worked through in the order of its phases: a held CR first,
    // then the byte itself, then the end of text. Beats land in fixed
    // candidate slots and are packed afterwards.
    always_comb
    begin
        mode_w  = mode_reg;
        slash_w = slash_reg;
        cr_w    = cr_reg;
        lc_w    = line_reg;
        tl_w    = tok_line_reg;
        done_w  = 1'b0;
        ev      = '0;
        cont_a  = cls_pkg::lex_content(mode_reg, cls_pkg::CH_CR);
        for (int i = 0; i < NCAND; i++) begin
            er[i] = '0;
            el[i] = '0;
        end

        if (cr_reg) begin
            cr_w = 1'b0;
            if (text_byte == cls_pkg::CH_LF) begin
                mode_w = cls_pkg::new_line_mode(mode_w);
                lc_w   = line_inc(lc_w);
                done_w = 1'b1;
            end else begin
                mode_w = cont_a.mode;
                if (cont_a.take)
                    tl_w = lc_w;
                if (cont_a.slash)
                    slash_w = 1'b1;
                ev[0] = cont_a.emit;
                er[0] = cont_a.res;
                el[0] = tl_w;
            end
        end

        cont_b = cls_pkg::lex_content(mode_w, text_byte);

        if (!done_w) begin
            if (text_byte == cls_pkg::CH_LF) begin
                if (slash_w) begin
                    slash_w = 1'b0;
                    ev[1]   = 1'b1;
                    er[1]   = '{has: 1'b1, ch: cls_pkg::CH_SLASH, start: 1'b1,
                                kind: cls_pkg::KIND_OP};
                    el[1]   = lc_w;
                end
                mode_w = cls_pkg::new_line_mode(mode_w);
                lc_w   = line_inc(lc_w);
            end else if (text_byte == cls_pkg::CH_CR &&
                         (mode_w == cls_pkg::MODE_STR || mode_w == cls_pkg::MODE_CHR)) begin
                if (!final_byte)
                    cr_w = 1'b1;
            end else if (text_byte == cls_pkg::CH_CR && final_byte) begin
                // A CR that ends the text is dropped.
            end else if (slash_w && text_byte == cls_pkg::CH_SLASH) begin
                slash_w = 1'b0;
                mode_w  = cls_pkg::MODE_LCOM;
            end else if (slash_w && text_byte == cls_pkg::CH_STAR) begin
                slash_w = 1'b0;
                mode_w  = cls_pkg::MODE_BCOM;
            end else begin
                if (slash_w) begin
                    slash_w = 1'b0;
                    ev[1]   = 1'b1;
                    er[1]   = '{has: 1'b1, ch: cls_pkg::CH_SLASH, start: 1'b1,
                                kind: cls_pkg::KIND_OP};
                    el[1]   = lc_w;
                end
                mode_w = cont_b.mode;
                if (cont_b.take)
                    tl_w = lc_w;
                if (cont_b.slash)
                    slash_w = 1'b1;
                ev[2] = cont_b.emit;
                er[2] = cont_b.res;
                el[2] = tl_w;
            end
        end

        if (final_byte) begin
            if (slash_w) begin
                slash_w = 1'b0;
                ev[3]   = 1'b1;
                er[3]   = '{has: 1'b1, ch: cls_pkg::CH_SLASH, start: 1'b1,
                            kind: cls_pkg::KIND_OP};
                el[3]   = lc_w;
            end
            // Bare end marker when the final byte gave no token byte.
            ev[4] = (ev[3:0] == '0);
            el[4] = lc_w;
        end

        found0     = 1'b0;
        found1     = 1'b0;
        push_info  = '0;
        push_line0 = '0;
        push_line1 = '0;
        for (int i = 0; i < NCAND; i++) begin
            if (ev[i]) begin
                if (!found0) begin
                    found0       = 1'b1;
                    push_info.r0 = er[i];
                    push_line0   = el[i];
                end else if (!found1) begin
                    found1       = 1'b1;
                    push_info.r1 = er[i];
                    push_line1   = el[i];
                end
            end
        end
        push_info.two = found1;
        push_info.fin = final_byte;
        push          = accept && found0;

        if (final_byte) begin
            mode_next     = cls_pkg::MODE_IDLE;
            slash_next    = 1'b0;
            cr_next       = 1'b0;
            line_next     = '0;
            tok_line_next = '0;
        end else begin
            mode_next     = mode_w;
            slash_next    = slash_w;
            cr_next       = cr_w;
            line_next     = lc_w;
            tok_line_next = tl_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg     <= cls_pkg::MODE_IDLE;
            slash_reg    <= 1'b0;
            cr_reg       <= 1'b0;
            line_reg     <= '0;
            tok_line_reg <= '0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            slash_reg    <= slash_next;
            cr_reg       <= cr_next;
            line_reg     <= line_next;
            tok_line_reg <= tok_line_next;
        end
    end

endmodule

`default_nettype wire

/* design/cls_queue.sv */
// ============================================================================
// cls_queue: short entry queue between lexer and output side
// Holds up to four entries, each the beats of one input byte.
// ============================================================================
`default_nettype none

module cls_queue #(
    parameter int LINE_BITS = 20
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire cls_pkg::cls_entry_t  push_info,
    input  wire logic [LINE_BITS-1:0] push_line0,
    input  wire logic [LINE_BITS-1:0] push_line1,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      head_valid,
    output cls_pkg::cls_entry_t       head_info,
    output logic [LINE_BITS-1:0]      head_line0,
    output logic [LINE_BITS-1:0]      head_line1
);

    localparam logic [cls_pkg::Q_PTR_BITS-1:0] PTR_LAST =
        cls_pkg::Q_PTR_BITS'(cls_pkg::Q_DEPTH - 1);
    localparam logic [cls_pkg::Q_CNT_BITS-1:0] CNT_FULL =
        cls_pkg::Q_CNT_BITS'(cls_pkg::Q_DEPTH);

    cls_pkg::cls_entry_t                 info_mem  [cls_pkg::Q_DEPTH];
    logic [LINE_BITS-1:0]                line0_mem [cls_pkg::Q_DEPTH];
    logic [LINE_BITS-1:0]                line1_mem [cls_pkg::Q_DEPTH];
    logic [cls_pkg::Q_PTR_BITS-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [cls_pkg::Q_PTR_BITS-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [cls_pkg::Q_CNT_BITS-1:0]      count_reg, count_next;
    logic                                do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;
    assign head_info  = info_mem[rd_ptr_reg];
    assign head_line0 = line0_mem[rd_ptr_reg];
    assign head_line1 = line1_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            info_mem[wr_ptr_reg]  <= push_info;
            line0_mem[wr_ptr_reg] <= push_line0;
            line1_mem[wr_ptr_reg] <= push_line1;
        end
    end

endmodule

`default_nettype wire

/* design/cls_back.sv */
// ============================================================================
// cls_back: output sequencer
// Sends the head entry out as one or two beats and frees it after its last.
// ============================================================================
`default_nettype none

module cls_back #(
    parameter int LINE_BITS = 20
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 head_valid,
    input  wire cls_pkg::cls_entry_t  head_info,
    input  wire logic [LINE_BITS-1:0] head_line0,
    input  wire logic [LINE_BITS-1:0] head_line1,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      has_char,
    output logic [7:0]                token_char,
    output logic                      token_start,
    output logic [1:0]                token_kind,
    output logic [LINE_BITS-1:0]      line_number,
    output logic                      run_last,
    output logic                      text_end
);

    logic              second_reg, second_next;
    logic              use_second, beat_done;
    cls_pkg::tok_res_t sel;

    assign use_second  = head_info.two && second_reg;
    assign sel         = use_second ? head_info.r1 : head_info.r0;
    assign out_valid   = head_valid;
    assign has_char    = sel.has;
    assign token_char  = sel.ch;
    assign token_start = sel.start;
    assign token_kind  = sel.kind;
    assign line_number = use_second ? head_line1 : head_line0;
    assign run_last    = !head_info.two || second_reg;
    assign text_end    = head_info.fin && run_last;
    assign beat_done   = head_valid && !out_stall;
    assign pop         = beat_done && run_last;

    always_comb
    begin
        second_next = second_reg;
        if (beat_done)
            second_next = !run_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_reg <= 1'b0;
        else
            second_reg <= second_next;
    end

endmodule

`default_nettype wire

/* design/c_like_script_tokenizer.sv */
// ============================================================================
// c_like_script_tokenizer: streaming tokenizer for C-like script text
// Strips whitespace and comments and tags every token byte with its kind,
// a token start flag and the line where the token began.
// ============================================================================
//
//  Channel | Handshake              | Beat contents
//  --------+------------------------+-----------------------------------------
//  input   | in_valid / in_stall    | text_byte, final_byte
//  output  | out_valid / out_stall  | has_char, token_char, token_start,
//          |                        | token_kind, line_number, run_last, text_end
//
//  The lexer decides one byte per cycle while the queue is not full and puts
//  each accepted byte's beats into the queue. A byte makes zero, one or two
//  beats; the output sends one beat per cycle while out_stall is low, so a
//  byte with two beats holds its entry until both are sent. The four-entry
//  queue lets input flow on while the output is stalled; in_stall rises only
//  when the queue is full. Reset clears the lexer state and empties the queue.
//
`default_nettype none

module c_like_script_tokenizer #(
    parameter int LINE_BITS = 20
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 final_byte,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      has_char,
    output logic [7:0]                token_char,
    output logic                      token_start,
    output logic [1:0]                token_kind,
    output logic [LINE_BITS-1:0]      line_number,
    output logic                      run_last,
    output logic                      text_end
);

    logic                 push, pop, q_full, head_valid;
    cls_pkg::cls_entry_t  push_info, head_info;
    logic [LINE_BITS-1:0] push_line0, push_line1, head_line0, head_line1;

    assign in_stall = q_full;

    cls_front #(.LINE_BITS(LINE_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .q_full     (q_full),
        .push       (push),
        .push_info  (push_info),
        .push_line0 (push_line0),
        .push_line1 (push_line1)
    );

    cls_queue #(.LINE_BITS(LINE_BITS)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_info  (push_info),
        .push_line0 (push_line0),
        .push_line1 (push_line1),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_info  (head_info),
        .head_line0 (head_line0),
        .head_line1 (head_line1)
    );

    cls_back #(.LINE_BITS(LINE_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_info   (head_info),
        .head_line0  (head_line0),
        .head_line1  (head_line1),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .has_char    (has_char),
        .token_char  (token_char),
        .token_start (token_start),
        .token_kind  (token_kind),
        .line_number (line_number),
        .run_last    (run_last),
        .text_end    (text_end)
    );

endmodule

`default_nettype wire

/* design/cls_checker.sv */
// ============================================================================
// cls_checker: port-level checks of the script tokenizer
// Watches the output beats for holding under stall and for consistent end and start flags.
// ============================================================================
`default_nettype none

module cls_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       has_char,
    input wire logic [7:0] token_char,
    input wire logic       token_start,
    input wire logic [1:0] token_kind,
    input wire logic       run_last,
    input wire logic       text_end
);

    // A stalled beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    // The end of a text is always the last beat of its byte.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_end |-> run_last)
        else $error("text_end without run_last");

    // A bare end marker carries no token byte and closes the text.
    a_bare: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> text_end && !token_start && token_char == 8'h00)
        else $error("malformed end marker");

    // A string literal opens with its double quote.
    a_str_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_char && token_start && token_kind == cls_pkg::KIND_STR
        |-> token_char == cls_pkg::CH_DQUOTE)
        else $error("string token does not start with a quote");

endmodule

bind c_like_script_tokenizer cls_checker u_cls_checker (.*);

`default_nettype wire

/* tb/sv/token_stream_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// token_stream_checker: predicts and checks the tokenizer's output beats
// Watches both channels, runs its own lexer on every accepted text byte,
// and compares each output beat with the oldest beat still owed.
// ============================================================================

module token_stream_checker #(
    parameter int LINE_BITS = 20
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 final_byte,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic                 has_char,
    input  wire logic [7:0]           token_char,
    input  wire logic                 token_start,
    input  wire logic [1:0]           token_kind,
    input  wire logic [LINE_BITS-1:0] line_number,
    input  wire logic                 run_last,
    input  wire logic                 text_end,
    output int                        fail_count,
    output int                        beats_owed
);

    typedef struct packed {
        logic                 has;
        logic [7:0]           ch;
        logic                 start;
        cls_pkg::tok_kind_t   kind;
        logic [LINE_BITS-1:0] line;
        logic                 last;
        logic                 tend;
    } tok_beat_t;

    tok_beat_t            owed_beats[$];
    tok_beat_t            step_buf[2];
    int                   step_n;
    tok_beat_t            want;

    cls_pkg::lex_mode_t   mode;
    logic                 slash_pend;
    logic                 cr_pend;
    logic [LINE_BITS-1:0] cur_line;
    logic [LINE_BITS-1:0] tok_line;

    initial
    begin
        fail_count = 0;
        beats_owed = 0;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return (c == cls_pkg::CH_SP) || (c == cls_pkg::CH_TAB) ||
               (c == cls_pkg::CH_CR) || (c == cls_pkg::CH_LF);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        string ops = "+-*/%=!&|><\\:;\"'()[]{}.,?#";
        for (int i = 0; i < ops.len(); i++)
        begin
            if (ops[i] == c)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic clear_lexer();
        mode       = cls_pkg::MODE_IDLE;
        slash_pend = 1'b0;
        cr_pend    = 1'b0;
        cur_line   = '0;
        tok_line   = '0;
    endtask

    task automatic add_beat(input logic has, input logic [7:0] ch, input logic start,
                            input cls_pkg::tok_kind_t kind,
                            input logic [LINE_BITS-1:0] ln);
        tok_beat_t b;
        b.has   = has;
        b.ch    = ch;
        b.start = start;
        b.kind  = kind;
        b.line  = ln;
        b.last  = 1'b0;
        b.tend  = 1'b0;
        if (step_n < 2)
        begin
            step_buf[step_n] = b;
            step_n++;
        end
    endtask

    task automatic line_break();
        if (cur_line != '1)
            cur_line = cur_line + 1'b1;
        if (mode == cls_pkg::MODE_WORD || mode == cls_pkg::MODE_LCOM)
            mode = cls_pkg::MODE_IDLE;
        else if (mode == cls_pkg::MODE_BSTAR)
            mode = cls_pkg::MODE_BCOM;
    endtask

    task automatic flush_slash();
        if (slash_pend)
        begin
            slash_pend = 1'b0;
            add_beat(1'b1, cls_pkg::CH_SLASH, 1'b1, cls_pkg::KIND_OP, cur_line);
        end
    endtask

    // One byte other than a line feed, with no slash pending.
    task automatic take_content(input logic [7:0] c);
        case (mode)
            cls_pkg::MODE_STR:
            begin
                add_beat(1'b1, c, 1'b0, cls_pkg::KIND_STR, tok_line);
                if (c == cls_pkg::CH_DQUOTE)
                    mode = cls_pkg::MODE_IDLE;
            end
            cls_pkg::MODE_CHR:
            begin
                add_beat(1'b1, c, 1'b0, cls_pkg::KIND_CHR, tok_line);
                if (c == cls_pkg::CH_SQUOTE)
                    mode = cls_pkg::MODE_IDLE;
            end
            cls_pkg::MODE_LCOM:
            begin
            end
            cls_pkg::MODE_BCOM:
            begin
                if (c == cls_pkg::CH_STAR)
                    mode = cls_pkg::MODE_BSTAR;
            end
            cls_pkg::MODE_BSTAR:
            begin
                if (c == cls_pkg::CH_SLASH)
                    mode = cls_pkg::MODE_IDLE;
                else if (c != cls_pkg::CH_STAR)
                    mode = cls_pkg::MODE_BCOM;
            end
            default:
            begin
                if (is_blank(c))
                begin
                    mode = cls_pkg::MODE_IDLE;
                end
                else if (is_punct(c))
                begin
                    mode     = cls_pkg::MODE_IDLE;
                    tok_line = cur_line;
                    if (c == cls_pkg::CH_DQUOTE)
                    begin
                        mode = cls_pkg::MODE_STR;
                        add_beat(1'b1, c, 1'b1, cls_pkg::KIND_STR, tok_line);
                    end
                    else if (c == cls_pkg::CH_SQUOTE)
                    begin
                        mode = cls_pkg::MODE_CHR;
                        add_beat(1'b1, c, 1'b1, cls_pkg::KIND_CHR, tok_line);
                    end
                    else if (c == cls_pkg::CH_SLASH)
                    begin
                        slash_pend = 1'b1;
                    end
                    else
                    begin
                        add_beat(1'b1, c, 1'b1, cls_pkg::KIND_OP, tok_line);
                    end
                end
                else if (mode == cls_pkg::MODE_WORD)
                begin
                    add_beat(1'b1, c, 1'b0, cls_pkg::KIND_WORD, tok_line);
                end
                else
                begin
                    mode     = cls_pkg::MODE_WORD;
                    tok_line = cur_line;
                    add_beat(1'b1, c, 1'b1, cls_pkg::KIND_WORD, tok_line);
                end
            end
        endcase
    endtask

    // Works out the beats that one accepted text byte causes.
    task automatic lex_byte(input logic [7:0] c, input logic fin);
        logic done;
        done   = 1'b0;
        step_n = 0;

        // A CR held inside a literal is dropped only when LF follows it.
        if (cr_pend)
        begin
            cr_pend = 1'b0;
            if (c == cls_pkg::CH_LF)
            begin
                line_break();
                done = 1'b1;
            end
            else
            begin
                take_content(cls_pkg::CH_CR);
            end
        end

        if (!done)
        begin
            if (c == cls_pkg::CH_LF)
            begin
                flush_slash();
                line_break();
            end
            else if (c == cls_pkg::CH_CR &&
                     (mode == cls_pkg::MODE_STR || mode == cls_pkg::MODE_CHR))
            begin
                if (!fin)
                    cr_pend = 1'b1;
            end
            else if (c == cls_pkg::CH_CR && fin)
            begin
            end
            else if (slash_pend)
            begin
                if (c == cls_pkg::CH_SLASH)
                begin
                    slash_pend = 1'b0;
                    mode       = cls_pkg::MODE_LCOM;
                end
                else if (c == cls_pkg::CH_STAR)
                begin
                    slash_pend = 1'b0;
                    mode       = cls_pkg::MODE_BCOM;
                end
                else
                begin
                    flush_slash();
                    take_content(c);
                end
            end
            else
            begin
                take_content(c);
            end
        end

        if (fin)
        begin
            flush_slash();
            if (step_n == 0)
                add_beat(1'b0, 8'h00, 1'b0, cls_pkg::KIND_WORD, cur_line);
            step_buf[step_n-1].tend = 1'b1;
            clear_lexer();
        end

        if (step_n > 0)
            step_buf[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            owed_beats = {owed_beats, step_buf[i]};
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_lexer();
            owed_beats.delete();
            beats_owed = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                lex_byte(text_byte, final_byte);
            if (out_valid && !out_stall)
            begin
                if (owed_beats.size() == 0)
                begin
                    $error("unexpected beat: token_char 0x%0h", token_char);
                    fail_count++;
                end
                else
                begin
                    want = owed_beats.pop_front();
                    check_field("has_char", 32'(want.has), 32'(has_char));
                    check_field("token_char", 32'(want.ch), 32'(token_char));
                    check_field("token_start", 32'(want.start), 32'(token_start));
                    check_field("token_kind", 32'(want.kind), 32'(token_kind));
                    check_field("line_number", 32'(want.line), 32'(line_number));
                    check_field("run_last", 32'(want.last), 32'(run_last));
                    check_field("text_end", 32'(want.tend), 32'(text_end));
                end
            end
            beats_owed = owed_beats.size();
        end
    end

endmodule

/* tb/sv/c_like_script_tokenizer_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// c_like_script_tokenizer_test: stimulus and verdict for the script tokenizer
// Feeds directed and random source texts under random stalls on both sides
// and reports the checker's result.
// ============================================================================

module c_like_script_tokenizer_test;

    localparam int LINE_BITS    = 20;
    localparam int RANDOM_BYTES = 1950;
    localparam int CALM_AFTER   = 1800;
    localparam int WATCHDOG     = 1000;
    localparam int LONG_HOLD    = 150;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           text_byte;
    logic                 final_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic                 has_char;
    logic [7:0]           token_char;
    logic                 token_start;
    logic [1:0]           token_kind;
    logic [LINE_BITS-1:0] line_number;
    logic                 run_last;
    logic                 text_end;

    int                   check_fails;
    int                   owed;
    bit                   calm = 1'b0;
    int                   bytes_sent = 0;
    int                   idle_cycles = 0;
    logic [7:0]           script[$];
    string                op_set = "+-*/%=!&|><\\:;\"'()[]{}.,?#";

    always #5 clk = ~clk;

    c_like_script_tokenizer #(
        .LINE_BITS(LINE_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .text_byte(text_byte),
        .final_byte(final_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .has_char(has_char),
        .token_char(token_char),
        .token_start(token_start),
        .token_kind(token_kind),
        .line_number(line_number),
        .run_last(run_last),
        .text_end(text_end)
    );

    token_stream_checker #(
        .LINE_BITS(LINE_BITS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .text_byte(text_byte),
        .final_byte(final_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .has_char(has_char),
        .token_char(token_char),
        .token_start(token_start),
        .token_kind(token_kind),
        .line_number(line_number),
        .run_last(run_last),
        .text_end(text_end),
        .fail_count(check_fails),
        .beats_owed(owed)
    );

    // Any accepted beat on either channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("c_like_script_tokenizer_test NOT OK");
                $finish;
            end
        end
    end

    // Output side: random stall bursts, quiet stretches, and a few long
    // holds that let the input queue fill up.
    initial
    begin
        int n;
        int cyc;
        int hold_at;
        cyc       = 0;
        hold_at   = 400;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!calm && cyc >= hold_at)
            begin
                out_stall <= 1'b1;
                n       = LONG_HOLD;
                hold_at = hold_at + 2100;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 11);
            end
            else
            begin
                out_stall <= 1'b0;
                n = $urandom_range(1, 40);
            end
            repeat (n) @(posedge clk);
            cyc = cyc + n;
        end
    end

    task automatic add_byte(input logic [7:0] b);
        script = {script, b};
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_final);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        text_byte  <= b;
        final_byte <= is_final;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_script();
        for (int i = 0; i < script.size(); i++)
            send_byte(script[i], i == script.size() - 1);
        script.delete();
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_word_byte();
        case ($urandom_range(0, 5))
            0: add_byte(8'(8'h61 + $urandom_range(0, 25)));
            1: add_byte(8'(8'h41 + $urandom_range(0, 25)));
            2: add_byte(8'(8'h30 + $urandom_range(0, 9)));
            3: add_byte(8'(8'h80 + $urandom_range(0, 127)));
            4: add_byte(8'($urandom_range(0, 8)));
            default: add_byte(8'($urandom_range(14, 31)));
        endcase
    endtask

    // Body of a string or character literal; mostly closed, sometimes not.
    task automatic add_literal_body(input logic [7:0] quote);
        logic [7:0] c;
        repeat ($urandom_range(0, 8))
        begin
            case ($urandom_range(0, 11))
                0: add_byte(cls_pkg::CH_CR);
                1: add_byte(cls_pkg::CH_LF);
                2:
                begin
                    add_byte(cls_pkg::CH_CR);
                    add_byte(cls_pkg::CH_LF);
                end
                default:
                begin
                    c = 8'($urandom_range(0, 255));
                    add_byte((c == quote) ? 8'h41 : c);
                end
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            add_byte(quote);
    endtask

    task automatic add_fragment();
        int pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            repeat ($urandom_range(1, 8))
                add_word_byte();
        end
        else if (pick < 38)
        begin
            add_byte(op_set[$urandom_range(0, op_set.len() - 1)]);
        end
        else if (pick < 48)
        begin
            add_byte(cls_pkg::CH_DQUOTE);
            add_literal_body(cls_pkg::CH_DQUOTE);
        end
        else if (pick < 55)
        begin
            add_byte(cls_pkg::CH_SQUOTE);
            add_literal_body(cls_pkg::CH_SQUOTE);
        end
        else if (pick < 62)
        begin
            queue_text("//");
            repeat ($urandom_range(0, 10))
            begin
                c = 8'($urandom_range(0, 255));
                add_byte((c == cls_pkg::CH_LF) ? 8'h63 : c);
            end
            add_byte(cls_pkg::CH_LF);
        end
        else if (pick < 70)
        begin
            queue_text("/*");
            repeat ($urandom_range(0, 10))
            begin
                case ($urandom_range(0, 5))
                    0: add_byte(cls_pkg::CH_STAR);
                    1: add_byte(cls_pkg::CH_LF);
                    2: add_byte(cls_pkg::CH_SLASH);
                    default: add_byte(8'($urandom_range(0, 255)));
                endcase
            end
            queue_text("*/");
        end
        else if (pick < 88)
        begin
            case ($urandom_range(0, 4))
                0: add_byte(cls_pkg::CH_SP);
                1: add_byte(cls_pkg::CH_TAB);
                2: add_byte(cls_pkg::CH_LF);
                3:
                begin
                    add_byte(cls_pkg::CH_CR);
                    add_byte(cls_pkg::CH_LF);
                end
                default: add_byte(cls_pkg::CH_CR);
            endcase
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int target;
        int stop_at;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        text_byte  <= 8'h00;
        final_byte <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Block comment whose opener star must not close it, a held slash
        // that turns into an operator, a CR inside a string both alone and
        // before LF, a line comment, and a text ending inside a literal.
        queue_text("w");
        add_byte(8'hff);
        queue_text("/*/*//q\"");
        add_byte(cls_pkg::CH_CR);
        queue_text("z");
        add_byte(cls_pkg::CH_CR);
        add_byte(cls_pkg::CH_LF);
        queue_text("\"//x");
        add_byte(cls_pkg::CH_LF);
        add_byte(8'h00);
        queue_text("'");
        add_byte(cls_pkg::CH_CR);
        send_script();
        // A final CR outside a literal is dropped, leaving a bare end beat.
        add_byte(cls_pkg::CH_CR);
        send_script();
        // Ends with a slash still held.
        queue_text("a/b*/");
        send_script();

        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            if (bytes_sent >= stop_at - RANDOM_BYTES + CALM_AFTER)
                calm <= 1'b1;
            target = $urandom_range(1, 120);
            while (script.size() < target)
                add_fragment();
            send_script();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (check_fails == 0)
            $display("c_like_script_tokenizer_test OK");
        else
            $display("c_like_script_tokenizer_test NOT OK");
        $finish;
    end

endmodule
